// File: rtl/core/pu_pkg.sv
// shared types, constants and helper functions of the permutation unranking block
`default_nettype none

package pu_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int RANK_W = 45;
	localparam int SIZE_W = 5;
	localparam int IDX_W = 4;

	// divider works on a zero-padded copy of the rank, several bits a cycle
	localparam int DIV_STEP = 8;
	localparam int DIV_W = 48;
	localparam int DIV_CHUNKS = DIV_W / DIV_STEP;

	// configuration register map (word index)
	localparam logic REG_PERM_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] PERM_SIZE_RESET = 5'd2;

	// one accepted rank on its way from the front to the back
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [SIZE_W-1:0] size;
		logic              err;
	} pu_item_t;

	// factorial of the element count
	function automatic logic [RANK_W-1:0] pu_factorial(input logic [SIZE_W-1:0] n);
		logic [RANK_W-1:0] f;
		unique case (n)
			5'd0, 5'd1: f = 45'd1;
			5'd2:       f = 45'd2;
			5'd3:       f = 45'd6;
			5'd4:       f = 45'd24;
			5'd5:       f = 45'd120;
			5'd6:       f = 45'd720;
			5'd7:       f = 45'd5040;
			5'd8:       f = 45'd40320;
			5'd9:       f = 45'd362880;
			5'd10:      f = 45'd3628800;
			5'd11:      f = 45'd39916800;
			5'd12:      f = 45'd479001600;
			5'd13:      f = 45'd6227020800;
			5'd14:      f = 45'd87178291200;
			5'd15:      f = 45'd1307674368000;
			default:    f = 45'd20922789888000;
		endcase
		return f;
	endfunction

	// number of set bits in a slot mask
	function automatic logic [SIZE_W-1:0] pu_popcount(input logic [MAX_ELEMENTS-1:0] v);
		logic [SIZE_W-1:0] c;
		c = '0;
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			c = c + SIZE_W'(v[k]);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pu_front.sv
// front end: takes rank beats, clamps the size and flags ranks out of range
`default_nettype none

module pu_front
	import pu_pkg::*;
(
	input  wire logic [SIZE_W-1:0] perm_size,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [RANK_W-1:0] rank,
	input  wire logic              q_full,
	output logic                   q_push,
	output pu_item_t               q_item
);

	logic [SIZE_W-1:0] size_eff;

	// saturate the configured size into the supported range
	always_comb begin
		if (perm_size < SIZE_W'(2)) begin
			size_eff = SIZE_W'(2);
		end else if (perm_size > SIZE_W'(MAX_ELEMENTS)) begin
			size_eff = SIZE_W'(MAX_ELEMENTS);
		end else begin
			size_eff = perm_size;
		end
	end

	// classify and hand the beat to the queue
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;
	assign q_item.rank = rank;
	assign q_item.size = size_eff;
	assign q_item.err = (rank >= pu_factorial(size_eff));

endmodule

`default_nettype wire

// File: rtl/core/pu_queue.sv
// two-entry queue between the front end and the back end
`default_nettype none

module pu_queue
	import pu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire pu_item_t push_item,
	output logic          full,
	input  wire logic     pop,
	output logic          not_empty,
	output pu_item_t      pop_item
);

	pu_item_t    entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push || pop)
		else $error("queue written while full");

endmodule

`default_nettype wire

// File: rtl/core/pu_back.sv
// back end: digit extraction, slot placement and result emission
`default_nettype none

module pu_back
	import pu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_not_empty,
	input  wire pu_item_t          q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [IDX_W-1:0]       position,
	output logic [IDX_W-1:0]       element,
	output logic                   last,
	output logic                   rank_error
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_PLACE = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]              state_q;
	logic [DIV_W-1:0]        rest_q;
	logic [IDX_W-1:0]        rem_q;
	logic [2:0]              chunk_q;
	logic [SIZE_W-1:0]       base_q;
	logic [IDX_W-1:0]        didx_q;
	logic [IDX_W-1:0]        cnt_q;
	logic [SIZE_W-1:0]       n_q;
	logic                    err_q;
	logic [MAX_ELEMENTS-1:0] taken_q;
	logic [IDX_W-1:0]        digit_q [MAX_ELEMENTS];
	logic [IDX_W-1:0]        slot_q [MAX_ELEMENTS];
	logic                    out_valid_q;
	logic [IDX_W-1:0]        position_q;
	logic [IDX_W-1:0]        element_q;
	logic                    last_q;
	logic                    rank_error_q;

	logic [IDX_W-1:0]        div_rem;
	logic [DIV_STEP-1:0]     div_quo;
	logic                    div_done;
	logic [IDX_W-1:0]        n_last;
	logic [MAX_ELEMENTS-1:0] free_slots;
	logic [IDX_W-1:0]        want;
	logic [IDX_W-1:0]        pick;
	logic                    out_free;
	logic                    emit_last;

	assign n_last = IDX_W'(n_q - SIZE_W'(1));
	assign q_pop = (state_q == ST_IDLE) && q_not_empty;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_last = err_q || (cnt_q == n_last);
	assign div_done = (chunk_q == 3'(DIV_CHUNKS - 1));

	// restoring division of the rest by the current base, a chunk of bits a cycle
	always_comb begin
		logic [IDX_W:0] t;
		logic [IDX_W-1:0] r;
		r = rem_q;
		div_quo = '0;
		for (int k = 0; k < DIV_STEP; k++) begin
			t = {r, rest_q[DIV_W-1-k]};
			if (t >= base_q) begin
				r = IDX_W'(t - base_q);
				div_quo[DIV_STEP-1-k] = 1'b1;
			end else begin
				r = t[IDX_W-1:0];
			end
		end
		div_rem = r;
	end

	// find the digit-th free slot among the first n
	always_comb begin
		logic [MAX_ELEMENTS-1:0] below;
		want = digit_q[cnt_q];
		for (int j = 0; j < MAX_ELEMENTS; j++) begin
			free_slots[j] = !taken_q[j] && (SIZE_W'(j) < n_q);
		end
		pick = n_last;
		for (int j = 0; j < MAX_ELEMENTS; j++) begin
			below = free_slots & ((MAX_ELEMENTS'(1) << j) - MAX_ELEMENTS'(1));
			if (free_slots[j] && (pu_popcount(below) == {1'b0, want})) begin
				pick = IDX_W'(j);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q <= '0;
			chunk_q <= '0;
			base_q <= SIZE_W'(2);
			didx_q <= '0;
			cnt_q <= '0;
			n_q <= SIZE_W'(2);
			err_q <= 1'b0;
			taken_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						n_q <= q_item.size;
						err_q <= q_item.err;
						rem_q <= '0;
						chunk_q <= '0;
						base_q <= SIZE_W'(2);
						didx_q <= IDX_W'(q_item.size - SIZE_W'(2));
						cnt_q <= '0;
						state_q <= q_item.err ? ST_EMIT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						rem_q <= '0;
						chunk_q <= '0;
						if (didx_q == '0) begin
							taken_q <= '0;
							cnt_q <= '0;
							state_q <= ST_PLACE;
						end else begin
							didx_q <= didx_q - IDX_W'(1);
							base_q <= base_q + SIZE_W'(1);
						end
					end else begin
						rem_q <= div_rem;
						chunk_q <= chunk_q + 3'd1;
					end
				end
				ST_PLACE: begin
					taken_q[pick] <= 1'b1;
					if (cnt_q == n_last) begin
						cnt_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register valid
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rest_q <= DIV_W'(q_item.rank);
		end else if (state_q == ST_DIV) begin
			rest_q <= {rest_q[DIV_W-DIV_STEP-1:0], div_quo};
			if (div_done) begin
				digit_q[didx_q] <= div_rem;
				if (didx_q == '0) begin
					digit_q[n_last] <= '0;
				end
			end
		end
		if (state_q == ST_PLACE) begin
			slot_q[pick] <= cnt_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			position_q <= err_q ? '0 : cnt_q;
			element_q <= err_q ? '0 : slot_q[cnt_q];
			last_q <= emit_last;
			rank_error_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign position = position_q;
	assign element = element_q;
	assign last = last_q;
	assign rank_error = rank_error_q;

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < base_q)
		else $error("division remainder not below base");

	a_place_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PLACE |-> $countones(taken_q) == cnt_q)
		else $error("taken slots disagree with placed elements");

	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !err_q |-> $countones(taken_q) == n_q)
		else $error("emission started before every slot was filled");

endmodule

`default_nettype wire

// File: rtl/core/permutation_unrank_factorial_base.sv
// top level of the permutation unranking block with its register port
`default_nettype none

// Turns each rank beat into a permutation of perm_size elements (2 to 16) in
// the factorial number system and returns one beat per slot, in slot order,
// carrying the element placed there, with last on the final beat. A rank at or
// above perm_size factorial yields a single beat with rank_error and last set.
// One rank at a time is worked on: a divider step per mixed-radix digit, then
// slot placement at one element per cycle and one result beat per cycle while
// out_stall is low; a rejected rank goes straight to its error beat. A
// two-entry queue behind the input lets up to two further ranks be taken
// meanwhile. perm_size sits at byte address 0.

module permutation_unrank_factorial_base
	import pu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [RANK_W-1:0] rank,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [IDX_W-1:0]       position,
	output logic [IDX_W-1:0]       element,
	output logic                   last,
	output logic                   rank_error
);

	logic [SIZE_W-1:0] perm_size_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_not_empty;
	pu_item_t          push_item;
	pu_item_t          pop_item;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PERM_SIZE) ? 32'(perm_size_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q <= PERM_SIZE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PERM_SIZE) begin
			perm_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// input classification
	pu_front u_front (
		.perm_size (perm_size_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rank      (rank),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// decoupling queue
	pu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	// unranking engine
	pu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position),
		.element     (element),
		.last        (last),
		.rank_error  (rank_error)
	);

endmodule

`default_nettype wire
